FILE: src/rsi_pkg.sv
// Shared widths, status codes and stage sideband types for the ray-sphere intersection core.
package rsi_pkg;

    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int CRD_W = 32;
    localparam int RAD_W = 31;
    localparam int OC_W  = CRD_W + 1;

    // Quadratic terms
    localparam int A_W  = 2 * CRD_W;
    localparam int H_W  = OC_W + CRD_W + 1;
    localparam int C_W  = 2 * OC_W + 1;
    localparam int HM_W = H_W - 1;
    localparam int CM_W = C_W - 1;
    localparam int HL_W = 33;
    localparam int CL_W = 33;
    localparam int AL_W = 32;
    localparam int Q_W  = 134;

    // Square root
    localparam int SQ_STEPS = Q_W / 2;
    localparam int S_W      = SQ_STEPS;
    localparam int R_W      = S_W + 4;

    // Division
    localparam int NUM_W = S_W + 2;
    localparam int LHS_W = NUM_W - 1 + FRAC_BITS;
    localparam int DQ_W  = CRD_W - 1;
    localparam int DIV_W = A_W + DQ_W;

    localparam logic [CRD_W-1:0] T_MAX = {1'b0, {(CRD_W-1){1'b1}}};
    localparam logic [CRD_W-1:0] T_MIN = {1'b1, {(CRD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_ZERO_DIR = 2'd2
    } status_t;

    // Carried alongside the square root
    typedef struct packed {
        status_t          st;
        logic [A_W-1:0]   a;
        logic [H_W-1:0]   h;
    } sq_side_t;

    // Carried alongside the divider
    typedef struct packed {
        status_t st;
        logic    neg;
        logic    sat;
    } dv_side_t;

endpackage

FILE: src/rsi_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
module rsi_sqrt
    import rsi_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vld_in,
    input  sq_side_t       side_in,
    input  logic [Q_W-1:0] rad_in,
    output logic           vld_out,
    output sq_side_t       side_out,
    output logic [S_W-1:0] root_out
);

    logic [SQ_STEPS-1:0] vld_reg;
    sq_side_t            side_reg  [SQ_STEPS];
    logic [R_W-1:0]      rem_reg   [SQ_STEPS];
    logic [S_W-1:0]      root_reg  [SQ_STEPS];
    logic [Q_W-1:0]      rad_reg   [SQ_STEPS];

    sq_side_t            side_src  [SQ_STEPS];
    logic [R_W-1:0]      rem_src   [SQ_STEPS];
    logic [S_W-1:0]      root_src  [SQ_STEPS];
    logic [Q_W-1:0]      rad_src   [SQ_STEPS];

    logic [R_W-1:0]      rem_next  [SQ_STEPS];
    logic [S_W-1:0]      root_next [SQ_STEPS];
    logic [Q_W-1:0]      rad_next  [SQ_STEPS];
    logic [R_W-1:0]      shifted   [SQ_STEPS];
    logic [R_W-1:0]      trial     [SQ_STEPS];

    always_comb
    begin
        side_src[0] = side_in;
        rem_src[0]  = '0;
        root_src[0] = '0;
        rad_src[0]  = rad_in;
        for (int k = 1; k < SQ_STEPS; k++)
        begin
            side_src[k] = side_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            rad_src[k]  = rad_reg[k-1];
        end
    end

    // bring down two radicand bits, try root*4+1
    always_comb
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            shifted[k]  = {rem_src[k][R_W-3:0], rad_src[k][Q_W-1 -: 2]};
            trial[k]    = R_W'({root_src[k], 2'b01});
            rad_next[k] = rad_src[k] << 2;
            if (shifted[k] >= trial[k])
            begin
                rem_next[k]  = shifted[k] - trial[k];
                root_next[k] = {root_src[k][S_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = shifted[k];
                root_next[k] = {root_src[k][S_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SQ_STEPS-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                side_reg[k] <= side_src[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign vld_out  = vld_reg[SQ_STEPS-1];
    assign side_out = side_reg[SQ_STEPS-1];
    assign root_out = root_reg[SQ_STEPS-1];

endmodule

FILE: src/rsi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rsi_div
    import rsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  dv_side_t         side_in,
    input  logic [LHS_W-1:0] dividend,
    input  logic [A_W-1:0]   divisor,
    output logic             vld_out,
    output dv_side_t         side_out,
    output logic [DQ_W-1:0]  quo_out
);

    logic [DQ_W-1:0]  vld_reg;
    dv_side_t         side_reg [DQ_W];
    logic [DIV_W-1:0] rem_reg  [DQ_W];
    logic [A_W-1:0]   dsr_reg  [DQ_W];
    logic [DQ_W-1:0]  quo_reg  [DQ_W];

    dv_side_t         side_src [DQ_W];
    logic [DIV_W-1:0] rem_src  [DQ_W];
    logic [A_W-1:0]   dsr_src  [DQ_W];
    logic [DQ_W-1:0]  quo_src  [DQ_W];

    logic [DIV_W-1:0] rem_next [DQ_W];
    logic [DQ_W-1:0]  quo_next [DQ_W];
    logic [DIV_W-1:0] scaled   [DQ_W];

    always_comb
    begin
        side_src[0] = side_in;
        rem_src[0]  = DIV_W'(dividend);
        dsr_src[0]  = divisor;
        quo_src[0]  = '0;
        for (int k = 1; k < DQ_W; k++)
        begin
            side_src[k] = side_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            dsr_src[k]  = dsr_reg[k-1];
            quo_src[k]  = quo_reg[k-1];
        end
    end

    // stage k settles quotient bit DQ_W-1-k
    always_comb
    begin
        for (int k = 0; k < DQ_W; k++)
        begin
            scaled[k] = DIV_W'(dsr_src[k]) << (DQ_W - 1 - k);
            if (rem_src[k] >= scaled[k])
            begin
                rem_next[k] = rem_src[k] - scaled[k];
                quo_next[k] = quo_src[k] | (DQ_W'(1) << (DQ_W - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_src[k];
                quo_next[k] = quo_src[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DQ_W-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DQ_W; k++)
            begin
                side_reg[k] <= side_src[k];
                rem_reg[k]  <= rem_next[k];
                dsr_reg[k]  <= dsr_src[k];
                quo_reg[k]  <= quo_next[k];
            end
        end
    end

    assign vld_out  = vld_reg[DQ_W-1];
    assign side_out = side_reg[DQ_W-1];
    assign quo_out  = quo_reg[DQ_W-1];

endmodule

FILE: src/ray_sphere_intersect_core.sv
// Ray-sphere intersection core: quadratic set-up, square root and divide, fully pipelined.
// Stages from an accepted item to its result: 7 set-up stages, 67 square-root stages,
// 3 numerator stages, 31 divider stages and 1 output register.
// Throughput: one item per cycle; every stage holds one item and the whole pipe advances
// together whenever the output register is empty or its item is being taken.
// Reset (rst_n low, asynchronous) clears all valid bits; payload registers are not reset.
module ray_sphere_intersect_core
    import rsi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [CRD_W-1:0] origin_x,
    input  logic signed [CRD_W-1:0] origin_y,
    input  logic signed [CRD_W-1:0] origin_z,
    input  logic signed [CRD_W-1:0] dir_x,
    input  logic signed [CRD_W-1:0] dir_y,
    input  logic signed [CRD_W-1:0] dir_z,
    input  logic signed [CRD_W-1:0] center_x,
    input  logic signed [CRD_W-1:0] center_y,
    input  logic signed [CRD_W-1:0] center_z,
    input  logic        [RAD_W-1:0] sphere_radius,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic        [1:0]       status,
    output logic signed [CRD_W-1:0] hit_distance
);

    // Advance the whole pipe unless a finished item is held at the output.
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // ------------------------------------------------------------------
    // Stage 1: offset from the centre, zero-direction flag
    // ------------------------------------------------------------------
    logic                    p1_vld_reg;
    logic signed [OC_W-1:0]  p1_oc_reg [3];
    logic signed [CRD_W-1:0] p1_d_reg  [3];
    logic        [RAD_W-1:0] p1_r_reg;
    logic                    p1_zdir_reg;

    logic signed [OC_W-1:0]  p1_oc_next [3];
    logic                    p1_zdir_next;

    always_comb
    begin
        p1_oc_next[0] = OC_W'(origin_x) - OC_W'(center_x);
        p1_oc_next[1] = OC_W'(origin_y) - OC_W'(center_y);
        p1_oc_next[2] = OC_W'(origin_z) - OC_W'(center_z);
        p1_zdir_next  = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    end

    // ------------------------------------------------------------------
    // Stage 2: component products
    // ------------------------------------------------------------------
    logic                         p2_vld_reg;
    logic        [A_W-1:0]        p2_dd_reg [3];
    logic signed [OC_W+CRD_W-1:0] p2_od_reg [3];
    logic signed [2*OC_W-1:0]     p2_oo_reg [3];
    logic        [2*RAD_W-1:0]    p2_rr_reg;
    logic                         p2_zdir_reg;

    logic signed [2*CRD_W-1:0]    p2_dd_prod [3];
    logic        [A_W-1:0]        p2_dd_next [3];
    logic signed [OC_W+CRD_W-1:0] p2_od_next [3];
    logic signed [2*OC_W-1:0]     p2_oo_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p2_dd_prod[i] = p1_d_reg[i] * p1_d_reg[i];
            p2_dd_next[i] = A_W'(p2_dd_prod[i]);
            p2_od_next[i] = p1_oc_reg[i] * p1_d_reg[i];
            p2_oo_next[i] = p1_oc_reg[i] * p1_oc_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: a = D.D, h = oc.D, c = oc.oc - r*r
    // ------------------------------------------------------------------
    logic                   p3_vld_reg;
    logic        [A_W-1:0]  p3_a_reg;
    logic signed [H_W-1:0]  p3_h_reg;
    logic signed [C_W-1:0]  p3_c_reg;
    logic                   p3_zdir_reg;

    logic        [A_W-1:0]  p3_a_next;
    logic signed [H_W-1:0]  p3_h_next;
    logic signed [C_W-1:0]  p3_c_next;

    always_comb
    begin
        p3_a_next = p2_dd_reg[0] + p2_dd_reg[1] + p2_dd_reg[2];
        p3_h_next = H_W'(p2_od_reg[0]) + H_W'(p2_od_reg[1]) + H_W'(p2_od_reg[2]);
        p3_c_next = C_W'(p2_oo_reg[0]) + C_W'(p2_oo_reg[1]) + C_W'(p2_oo_reg[2])
                  - signed'(C_W'(p2_rr_reg));
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes of h and c
    // ------------------------------------------------------------------
    logic                   p4_vld_reg;
    logic        [HM_W-1:0] p4_hm_reg;
    logic        [CM_W-1:0] p4_cm_reg;
    logic                   p4_cneg_reg;
    logic        [A_W-1:0]  p4_a_reg;
    logic signed [H_W-1:0]  p4_h_reg;
    logic                   p4_zdir_reg;

    logic        [H_W-1:0]  p4_habs;
    logic        [C_W-1:0]  p4_cabs;

    always_comb
    begin
        p4_habs = p3_h_reg[H_W-1] ? H_W'(-p3_h_reg) : H_W'(p3_h_reg);
        p4_cabs = p3_c_reg[C_W-1] ? C_W'(-p3_c_reg) : C_W'(p3_c_reg);
    end

    // ------------------------------------------------------------------
    // Stage 5: partial products of h*h and a*|c|
    // ------------------------------------------------------------------
    logic                         p5_vld_reg;
    logic [2*(HM_W-HL_W)-1:0]     p5_hhh_reg;
    logic [HM_W-1:0]              p5_hhl_reg;
    logic [2*HL_W-1:0]            p5_hll_reg;
    logic [A_W-AL_W+CM_W-CL_W-1:0] p5_ahch_reg;
    logic [A_W-AL_W+CL_W-1:0]     p5_ahcl_reg;
    logic [AL_W+CM_W-CL_W-1:0]    p5_alch_reg;
    logic [AL_W+CL_W-1:0]         p5_alcl_reg;
    logic                         p5_cneg_reg;
    logic        [A_W-1:0]        p5_a_reg;
    logic signed [H_W-1:0]        p5_h_reg;
    logic                         p5_zdir_reg;

    logic [HM_W-HL_W-1:0] hh_part;
    logic [HL_W-1:0]      hl_part;
    logic [A_W-AL_W-1:0]  ah_part;
    logic [AL_W-1:0]      al_part;
    logic [CM_W-CL_W-1:0] ch_part;
    logic [CL_W-1:0]      cl_part;

    always_comb
    begin
        hh_part = p4_hm_reg[HM_W-1:HL_W];
        hl_part = p4_hm_reg[HL_W-1:0];
        ah_part = p4_a_reg[A_W-1:AL_W];
        al_part = p4_a_reg[AL_W-1:0];
        ch_part = p4_cm_reg[CM_W-1:CL_W];
        cl_part = p4_cm_reg[CL_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 6: recombine h*h and a*|c|
    // ------------------------------------------------------------------
    logic                   p6_vld_reg;
    logic [Q_W-1:0]         p6_h2_reg;
    logic [Q_W-1:0]         p6_ac_reg;
    logic                   p6_cneg_reg;
    logic        [A_W-1:0]  p6_a_reg;
    logic signed [H_W-1:0]  p6_h_reg;
    logic                   p6_zdir_reg;

    logic [Q_W-1:0] p6_h2_next;
    logic [Q_W-1:0] p6_ac_next;

    always_comb
    begin
        p6_h2_next = (Q_W'(p5_hhh_reg) << (2 * HL_W))
                   + (Q_W'(p5_hhl_reg) << (HL_W + 1))
                   +  Q_W'(p5_hll_reg);
        p6_ac_next = (Q_W'(p5_ahch_reg) << (AL_W + CL_W))
                   + (Q_W'(p5_ahcl_reg) << AL_W)
                   + (Q_W'(p5_alch_reg) << CL_W)
                   +  Q_W'(p5_alcl_reg);
    end

    // ------------------------------------------------------------------
    // Stage 7: quarter discriminant, status decision
    // ------------------------------------------------------------------
    logic                   p7_vld_reg;
    logic [Q_W-1:0]         p7_q_reg;
    sq_side_t               p7_side_reg;

    logic [Q_W-1:0]         p7_q_next;
    status_t                p7_st_next;

    always_comb
    begin
        p7_q_next = p6_cneg_reg ? (p6_h2_reg + p6_ac_reg) : (p6_h2_reg - p6_ac_reg);
        // zero direction takes precedence over a miss
        if (p6_zdir_reg)
        begin
            p7_st_next = ST_ZERO_DIR;
        end
        else if (p7_q_next[Q_W-1])
        begin
            p7_st_next = ST_MISS;
        end
        else
        begin
            p7_st_next = ST_HIT;
        end
    end

    // ------------------------------------------------------------------
    // Square root of the discriminant
    // ------------------------------------------------------------------
    logic           sq_vld;
    sq_side_t       sq_side;
    logic [S_W-1:0] sq_root;

    rsi_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (p7_vld_reg),
        .side_in  (p7_side_reg),
        .rad_in   (p7_q_reg),
        .vld_out  (sq_vld),
        .side_out (sq_side),
        .root_out (sq_root)
    );

    // ------------------------------------------------------------------
    // Stage 8: numerator -h - sqrt(Q)
    // ------------------------------------------------------------------
    logic             p8_vld_reg;
    logic [NUM_W-1:0] p8_num_reg;
    logic [A_W-1:0]   p8_a_reg;
    status_t          p8_st_reg;

    logic [NUM_W-1:0] p8_num_next;

    always_comb
    begin
        p8_num_next = NUM_W'(0)
                    - {{(NUM_W-H_W){sq_side.h[H_W-1]}}, sq_side.h}
                    - NUM_W'(sq_root);
    end

    // ------------------------------------------------------------------
    // Stage 9: scaled magnitude of the numerator
    // ------------------------------------------------------------------
    logic             p9_vld_reg;
    logic [LHS_W-1:0] p9_lhs_reg;
    logic             p9_neg_reg;
    logic [A_W-1:0]   p9_a_reg;
    status_t          p9_st_reg;

    logic [NUM_W-1:0] p9_mag;

    always_comb
    begin
        p9_mag = p8_num_reg[NUM_W-1] ? (NUM_W'(0) - p8_num_reg) : p8_num_reg;
    end

    // ------------------------------------------------------------------
    // Stage 10: saturation check against a * 2^31
    // ------------------------------------------------------------------
    logic             p10_vld_reg;
    logic [LHS_W-1:0] p10_lhs_reg;
    logic [A_W-1:0]   p10_a_reg;
    dv_side_t         p10_side_reg;

    logic             p10_sat_next;

    always_comb
    begin
        p10_sat_next = DIV_W'(p9_lhs_reg) >= (DIV_W'(p9_a_reg) << DQ_W);
    end

    // ------------------------------------------------------------------
    // Quotient |num| * 2^FRAC_BITS / a
    // ------------------------------------------------------------------
    logic            dv_vld;
    dv_side_t        dv_side;
    logic [DQ_W-1:0] dv_quo;

    rsi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (p10_vld_reg),
        .side_in  (p10_side_reg),
        .dividend (p10_lhs_reg),
        .divisor  (p10_a_reg),
        .vld_out  (dv_vld),
        .side_out (dv_side),
        .quo_out  (dv_quo)
    );

    // ------------------------------------------------------------------
    // Output register: sign, saturation, zero unless hit
    // ------------------------------------------------------------------
    status_t          out_status_reg;
    logic [CRD_W-1:0] out_dist_reg;
    logic [CRD_W-1:0] out_dist_next;

    always_comb
    begin
        if (dv_side.st != ST_HIT)
        begin
            out_dist_next = '0;
        end
        else if (dv_side.sat)
        begin
            out_dist_next = dv_side.neg ? T_MIN : T_MAX;
        end
        else if (dv_side.neg)
        begin
            out_dist_next = CRD_W'(0) - CRD_W'(dv_quo);
        end
        else
        begin
            out_dist_next = CRD_W'(dv_quo);
        end
    end

    // Valid bits: cleared by reset, advance with the pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            p3_vld_reg    <= 1'b0;
            p4_vld_reg    <= 1'b0;
            p5_vld_reg    <= 1'b0;
            p6_vld_reg    <= 1'b0;
            p7_vld_reg    <= 1'b0;
            p8_vld_reg    <= 1'b0;
            p9_vld_reg    <= 1'b0;
            p10_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg    <= in_valid;
            p2_vld_reg    <= p1_vld_reg;
            p3_vld_reg    <= p2_vld_reg;
            p4_vld_reg    <= p3_vld_reg;
            p5_vld_reg    <= p4_vld_reg;
            p6_vld_reg    <= p5_vld_reg;
            p7_vld_reg    <= p6_vld_reg;
            p8_vld_reg    <= sq_vld;
            p9_vld_reg    <= p8_vld_reg;
            p10_vld_reg   <= p9_vld_reg;
            out_valid_reg <= dv_vld;
        end
    end

    // Payload: hold while stalled, advance otherwise.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_oc_reg    <= p1_oc_next;
            p1_d_reg[0]  <= dir_x;
            p1_d_reg[1]  <= dir_y;
            p1_d_reg[2]  <= dir_z;
            p1_r_reg     <= sphere_radius;
            p1_zdir_reg  <= p1_zdir_next;

            p2_dd_reg    <= p2_dd_next;
            p2_od_reg    <= p2_od_next;
            p2_oo_reg    <= p2_oo_next;
            p2_rr_reg    <= p1_r_reg * p1_r_reg;
            p2_zdir_reg  <= p1_zdir_reg;

            p3_a_reg     <= p3_a_next;
            p3_h_reg     <= p3_h_next;
            p3_c_reg     <= p3_c_next;
            p3_zdir_reg  <= p2_zdir_reg;

            p4_hm_reg    <= p4_habs[HM_W-1:0];
            p4_cm_reg    <= p4_cabs[CM_W-1:0];
            p4_cneg_reg  <= p3_c_reg[C_W-1];
            p4_a_reg     <= p3_a_reg;
            p4_h_reg     <= p3_h_reg;
            p4_zdir_reg  <= p3_zdir_reg;

            p5_hhh_reg   <= hh_part * hh_part;
            p5_hhl_reg   <= hh_part * hl_part;
            p5_hll_reg   <= hl_part * hl_part;
            p5_ahch_reg  <= ah_part * ch_part;
            p5_ahcl_reg  <= ah_part * cl_part;
            p5_alch_reg  <= al_part * ch_part;
            p5_alcl_reg  <= al_part * cl_part;
            p5_cneg_reg  <= p4_cneg_reg;
            p5_a_reg     <= p4_a_reg;
            p5_h_reg     <= p4_h_reg;
            p5_zdir_reg  <= p4_zdir_reg;

            p6_h2_reg    <= p6_h2_next;
            p6_ac_reg    <= p6_ac_next;
            p6_cneg_reg  <= p5_cneg_reg;
            p6_a_reg     <= p5_a_reg;
            p6_h_reg     <= p5_h_reg;
            p6_zdir_reg  <= p5_zdir_reg;

            p7_q_reg        <= p7_q_next;
            p7_side_reg.st  <= p7_st_next;
            p7_side_reg.a   <= p6_a_reg;
            p7_side_reg.h   <= p6_h_reg;

            p8_num_reg   <= p8_num_next;
            p8_a_reg     <= sq_side.a;
            p8_st_reg    <= sq_side.st;

            p9_lhs_reg   <= {p9_mag[NUM_W-2:0], {FRAC_BITS{1'b0}}};
            p9_neg_reg   <= p8_num_reg[NUM_W-1];
            p9_a_reg     <= p8_a_reg;
            p9_st_reg    <= p8_st_reg;

            p10_lhs_reg      <= p9_lhs_reg;
            p10_a_reg        <= p9_a_reg;
            p10_side_reg.st  <= p9_st_reg;
            p10_side_reg.neg <= p9_neg_reg;
            p10_side_reg.sat <= p10_sat_next;

            out_status_reg <= dv_side.st;
            out_dist_reg   <= out_dist_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign hit_distance = out_dist_reg;

endmodule

FILE: src/rsi_checker.sv
// Port-level checks for the ray-sphere intersection core, bound to its top level.
module rsi_checker
    import rsi_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [1:0]       status,
    input logic [CRD_W-1:0] hit_distance
);

    // input is held back only by a result waiting at a stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked output");

    // anything but a hit reports zero distance
    a_zero_unless_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_HIT) |-> (hit_distance == '0))
        else $error("non-hit item with non-zero distance");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(hit_distance)))
        else $error("stalled result changed");

endmodule

bind ray_sphere_intersect_core rsi_checker u_rsi_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for the fixed-point ray-sphere intersection core.
`timescale 1ns / 1ps

module tb_top
    import rsi_pkg::*;
();

    localparam int LIMIT      = 400000;
    localparam int N_RANDOM   = 600;
    localparam int DRAIN_WAIT = 130;   // comfortably longer than the pipe
    localparam int WW         = 200;   // wide enough for every exact term

    typedef struct {
        logic signed [CRD_W-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
        logic        [RAD_W-1:0] rad;
    } ray_t;

    typedef struct {
        status_t           st;
        logic [CRD_W-1:0]  distance;
    } hit_t;

    // Directed stimulus: a ray, and where it is obvious, the answer typed in
    typedef struct {
        ray_t  r;
        bit    typed;
        hit_t  want;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [CRD_W-1:0] origin_x, origin_y, origin_z;
    logic signed [CRD_W-1:0] dir_x, dir_y, dir_z;
    logic signed [CRD_W-1:0] center_x, center_y, center_z;
    logic        [RAD_W-1:0] sphere_radius;
    logic        [1:0]       status;
    logic signed [CRD_W-1:0] hit_distance;

    hit_t hits_due[$];
    int   n_sent;
    int   n_seen;
    int   cycles;
    bit   failed;
    bit   quiet;    // no idling on either side while set

    ray_sphere_intersect_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .origin_z      (origin_z),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .hit_distance  (hit_distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Solve the quadratic exactly in wide signed integers, then take the nearer
    // root with a floor square root and a truncating divide, saturated to 32 bits.
    function automatic hit_t solve_ray(input ray_t r);
        logic signed [WW-1:0] ocx, ocy, ocz, ddx, ddy, ddz, rr;
        logic signed [WW-1:0] a, h, c, q, s, trial, num, lhs, lim, mag;
        hit_t res;
        ocx = r.ox - r.cx;
        ocy = r.oy - r.cy;
        ocz = r.oz - r.cz;
        ddx = r.dx;
        ddy = r.dy;
        ddz = r.dz;
        rr  = r.rad;
        res.distance = '0;
        // zero direction is caught before anything else
        if (ddx == 0 && ddy == 0 && ddz == 0)
        begin
            res.st = ST_ZERO_DIR;
            return res;
        end
        a = ddx * ddx + ddy * ddy + ddz * ddz;
        h = ocx * ddx + ocy * ddy + ocz * ddz;
        c = ocx * ocx + ocy * ocy + ocz * ocz - rr * rr;
        q = h * h - a * c;
        if (q < 0)
        begin
            res.st = ST_MISS;
            return res;
        end
        s = '0;
        for (int b = 66; b >= 0; b--)
        begin
            trial = s;
            trial[b] = 1'b1;
            if (trial * trial <= q)
                s = trial;
        end
        num = -h - s;
        lhs = (num < 0 ? -num : num) <<< FRAC_BITS;
        lim = a <<< 31;
        res.st = ST_HIT;
        if (lhs >= lim)
            res.distance = (num < 0) ? T_MIN : T_MAX;
        else
        begin
            mag = lhs / a;
            res.distance = (num < 0) ? -mag[CRD_W-1:0] : mag[CRD_W-1:0];
        end
        return res;
    endfunction

    function automatic int spread(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly rays aimed near a sphere of modest size, so hits, misses,
    // rays from inside and zero directions all turn up; the rest is raw noise over every bit.
    function automatic ray_t rand_ray();
        ray_t r;
        int   kind;
        kind = $urandom_range(0, 19);
        if (kind < 4)
        begin
            r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
            r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
            r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
            r.rad = $urandom;
        end
        else
        begin
            r.cx = spread(1 << 24);
            r.cy = spread(1 << 24);
            r.cz = spread(1 << 24);
            r.ox = r.cx + spread(1 << 23);
            r.oy = r.cy + spread(1 << 23);
            r.oz = r.cz + spread(1 << 23);
            r.rad = $urandom_range(0, 1 << 22);
            if (kind == 4)
            begin
                r.dx = '0; r.dy = '0; r.dz = '0;
            end
            else
            begin
                r.dx = spread(1 << 17);
                r.dy = spread(1 << 17);
                r.dz = spread(1 << 17);
            end
        end
        return r;
    endfunction

    // Offer one item after a random gap, hold it until taken, then log its answer.
    task automatic offer_ray(input ray_t r, input bit typed, input hit_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
        dir_x    <= r.dx; dir_y    <= r.dy; dir_z    <= r.dz;
        center_x <= r.cx; center_y <= r.cy; center_z <= r.cz;
        sphere_radius <= r.rad;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        hits_due.push_back(typed ? want : solve_ray(r));
        n_sent++;
    endtask

    function automatic ray_t mk(input int ox, oy, oz, dx, dy, dz, cx, cy, cz,
                                input int rad);
        ray_t r;
        r.ox = ox; r.oy = oy; r.oz = oz;
        r.dx = dx; r.dy = dy; r.dz = dz;
        r.cx = cx; r.cy = cy; r.cz = cz;
        r.rad = rad;
        return r;
    endfunction

    // Receiver: stall for a random count, then take the next item and check it.
    // Once, hold off for a long stretch so the whole pipe stalls and holds back its input.
    initial
    begin
        int   hold;
        hit_t want;
        forever
        begin
            if (n_seen == 150)
                hold = 400;
            else
                hold = quiet ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            n_seen++;
            if (hits_due.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d distance %h",
                         $time, status, hit_distance);
                failed = 1'b1;
            end
            else
            begin
                want = hits_due.pop_front();
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, status);
                    failed = 1'b1;
                end
                if (hit_distance !== want.distance)
                begin
                    $display("%0t: hit_distance expected %h actual %h",
                             $time, want.distance, hit_distance);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("ray_sphere_intersect_core test failed");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        ray_t r;
        localparam int ONE = 1 << FRAC_BITS;
        localparam int PMAX = 32'h7FFFFFFF;
        localparam int NMIN = 32'h80000000;

        in_valid = 1'b0;
        out_stall = 1'b0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        center_x = '0; center_y = '0; center_z = '0;
        sphere_radius = '0;
        n_sent = 0;
        n_seen = 0;
        cycles = 0;
        failed = 1'b0;
        quiet = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero direction, both with and without a sphere around the origin
        rw.typed = 1'b1;
        rw.r = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        rw.want = '{ST_ZERO_DIR, '0};                      rows.push_back(rw);
        rw.r = mk(PMAX, NMIN, 5, 0, 0, 0, 1, 2, 3, PMAX);  rows.push_back(rw);
        // clean miss: passes ten units beside a unit sphere
        rw.r = mk(10 * ONE, 0, 0, 0, ONE, 0, 0, 0, 0, ONE);
        rw.want = '{ST_MISS, '0};                          rows.push_back(rw);
        // straight on from five units away: t = 4
        rw.r = mk(0, 0, -5 * ONE, 0, 0, ONE, 0, 0, 0, ONE);
        rw.want = '{ST_HIT, 32'h0004_0000};                rows.push_back(rw);

        rw.typed = 1'b0;
        // grazing tangent, start inside, hit behind the origin
        rows.push_back('{mk(ONE, 0, -5 * ONE, 0, 0, ONE, 0, 0, 0, ONE), 1'b0, rw.want});
        rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 3 * ONE), 1'b0, rw.want});
        rows.push_back('{mk(0, 0, 5 * ONE, 0, 0, ONE, 0, 0, 0, ONE), 1'b0, rw.want});
        // saturating both ways: tiny direction across the whole range
        rows.push_back('{mk(0, 0, NMIN, 0, 0, 1, 0, 0, PMAX, PMAX), 1'b0, rw.want});
        rows.push_back('{mk(0, 0, NMIN, 0, 0, -1, 0, 0, PMAX, PMAX), 1'b0, rw.want});
        // field extremes
        rows.push_back('{mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, NMIN, NMIN, NMIN, PMAX),
                         1'b0, rw.want});
        rows.push_back('{mk(NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, PMAX),
                         1'b0, rw.want});
        rows.push_back('{mk(NMIN, PMAX, 0, NMIN, NMIN, NMIN, NMIN, PMAX, 0, 0),
                         1'b0, rw.want});
        rows.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, PMAX), 1'b0, rw.want});
        rows.push_back('{mk(0, 0, 0, 1, 0, 0, 0, 0, 0, 1), 1'b0, rw.want});
        rows.push_back('{mk(0, 0, 0, PMAX, 0, 0, PMAX, 0, 0, 0), 1'b0, rw.want});

        foreach (rows[i])
            offer_ray(rows[i].r, rows[i].typed, rows[i].want);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // a back-to-back stretch with no idling on either side
            quiet = (i >= 300 && i < 380);
            r = rand_ray();
            offer_ray(r, 1'b0, rw.want);
        end
        quiet = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (!failed)
            $display("ray_sphere_intersect_core test passed");
        else
            $display("ray_sphere_intersect_core test failed");
        $finish;
    end

endmodule

FILE: sim.f
src/rsi_pkg.sv
src/rsi_sqrt.sv
src/rsi_div.sv
src/ray_sphere_intersect_core.sv
src/rsi_checker.sv
tb/tb_top.sv
